// File: design/periodic_timer_queue_assert.svh
// assertion macros for the timer queue
// no dependencies
`ifndef PERIODIC_TIMER_QUEUE_ASSERT_SVH
`define PERIODIC_TIMER_QUEUE_ASSERT_SVH

// condition implies consequence in the same cycle
`define PTQ_ASSERT_NOW(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error("ptq assertion failed");

// condition implies consequence in the next cycle
`define PTQ_ASSERT_NEXT(lbl, clk, rst_n, cond, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error("ptq assertion failed");

`endif

// File: design/ptq_pkg.sv
// types and constants of the periodic timer queue
// no dependencies
`timescale 1ns / 1ps
package ptq_pkg;
  localparam int DEPTH       = 16;
  localparam int TIME_BITS   = 48;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = $clog2(DEPTH);
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int DUE_W       = $clog2(MAX_RESULTS);
  localparam int NUM_W       = $clog2(MAX_RESULTS + 1);
  localparam int KIND_BITS   = 2;
  localparam int SLOT_BITS   = 4;
  localparam int STATUS_BITS = 3;

  typedef enum logic [KIND_BITS-1:0] {
    KIND_ADD  = 2'd0,
    KIND_DEL  = 2'd1,
    KIND_TICK = 2'd2,
    KIND_NONE = 2'd3
  } kind_t;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_FIRED    = 3'd0,
    ST_ADDED    = 3'd1,
    ST_DELETED  = 3'd2,
    ST_FULL     = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    logic [KIND_BITS-1:0] kind;
    logic [SLOT_BITS-1:0] slot;
    logic [TIME_BITS-1:0] time_value;
    logic [TIME_BITS-1:0] period;
  } cmd_t;

  typedef struct packed {
    logic [STATUS_BITS-1:0] status;
    logic [SLOT_BITS-1:0]   slot_id;
    logic [TIME_BITS-1:0]   due_time;
    logic                   last;
  } res_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_DEL_RD,
    S_DEL_EMIT,
    S_TK_RD,
    S_TK_CMP,
    S_FI_RD,
    S_FI_EMIT,
    S_INS_RD,
    S_INS_CMP,
    S_INS_PUT
  } eng_state_t;
endpackage

// File: design/ptq_if.sv
// valid/ready channel interfaces for command and result beats
// depends on ptq_pkg
`timescale 1ns / 1ps
interface ptq_in_if import ptq_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [KIND_BITS-1:0] kind;
  logic [SLOT_BITS-1:0] slot;
  logic [TIME_BITS-1:0] time_value;
  logic [TIME_BITS-1:0] period;
  modport source (output valid, kind, slot, time_value, period, input ready);
  modport sink (input valid, kind, slot, time_value, period, output ready);
endinterface

interface ptq_out_if import ptq_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [STATUS_BITS-1:0] status;
  logic [SLOT_BITS-1:0]   slot_id;
  logic [TIME_BITS-1:0]   due_time;
  logic                   last;
  modport source (output valid, status, slot_id, due_time, last, input ready);
  modport sink (input valid, status, slot_id, due_time, last, output ready);
endinterface

// File: design/ptq_front.sv
// front end: accepts command beats, drops KIND_NONE beats, two-entry queue
// depends on ptq_pkg and ptq_if
`timescale 1ns / 1ps
module ptq_front import ptq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ptq_in_if.sink    in_ch,
  output logic      cmd_valid,
  output cmd_t      cmd,
  input  logic      cmd_pop
);
  cmd_t       q_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       push;

  assign in_ch.ready = (cnt_r != 2'd2);
  assign push = in_ch.valid && in_ch.ready && (in_ch.kind != KIND_NONE);
  assign cmd_valid = (cnt_r != 2'd0);
  assign cmd = q_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (cmd_pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, cmd_pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wp_r] <= '{kind: in_ch.kind, slot: in_ch.slot,
                     time_value: in_ch.time_value, period: in_ch.period};
    end
  end
endmodule

// File: design/ptq_back.sv
// back end: slot stores, deadline-ordered list, sequencer and result register
// depends on ptq_pkg, ptq_if and periodic_timer_queue_assert.svh
`timescale 1ns / 1ps
`include "periodic_timer_queue_assert.svh"
module ptq_back import ptq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      cmd_valid,
  input  cmd_t      cmd,
  output logic      cmd_pop,
  ptq_out_if.source out_ch
);
  logic [TIME_BITS-1:0] dl_mem [DEPTH];
  logic [TIME_BITS-1:0] pr_mem [DEPTH];
  logic [TIME_BITS-1:0] dl_rd_r, pr_rd_r;
  logic [SLOT_W-1:0]    rd_addr;
  logic                 dl_we, pr_we;
  logic [SLOT_W-1:0]    wr_addr;
  logic [TIME_BITS-1:0] wr_dl;

  eng_state_t           state_r, state_nxt;
  logic [DEPTH-1:0]     valid_r, valid_nxt;
  logic [SLOT_W-1:0]    list_r [DEPTH];
  logic [SLOT_W-1:0]    list_nxt [DEPTH];
  logic [SLOT_W-1:0]    due_r [MAX_RESULTS];
  logic [SLOT_W-1:0]    due_nxt [MAX_RESULTS];
  logic [CNT_W-1:0]     cnt_r, cnt_nxt;
  logic [CNT_W-1:0]     pos_r, pos_nxt;
  logic [NUM_W-1:0]     n_r, n_nxt;
  logic [DUE_W-1:0]     i_r, i_nxt;
  cmd_t                 cmd_r, cmd_nxt;
  logic [TIME_BITS-1:0] ins_d_r, ins_d_nxt;
  logic [SLOT_W-1:0]    ins_s_r, ins_s_nxt;
  logic                 ins_tick_r, ins_tick_nxt;
  res_t                 out_r, out_nxt;
  logic                 out_valid_r, out_valid_nxt;

  logic                 out_free;
  logic                 any_free;
  logic [SLOT_W-1:0]    free_s;
  logic [SLOT_W-1:0]    hit_pos;
  logic                 req_ok;
  logic [SLOT_W-1:0]    req_s;
  logic [TIME_BITS:0]   sum;
  logic [TIME_BITS-1:0] rearm;
  logic                 last_fire;
  logic [SLOT_W-1:0]    fire_s;

  assign out_free  = !out_valid_r || out_ch.ready;
  assign req_ok    = (32'(cmd_r.slot) < DEPTH);
  assign req_s     = SLOT_W'(cmd_r.slot);
  assign sum       = {1'b0, dl_rd_r} + {1'b0, pr_rd_r};
  assign rearm     = sum[TIME_BITS] ? {TIME_BITS{1'b1}} : sum[TIME_BITS-1:0];
  assign last_fire = (NUM_W'(i_r) + NUM_W'(1)) == n_r;
  assign fire_s    = due_r[i_r];

  assign out_ch.valid    = out_valid_r;
  assign out_ch.status   = out_r.status;
  assign out_ch.slot_id  = out_r.slot_id;
  assign out_ch.due_time = out_r.due_time;
  assign out_ch.last     = out_r.last;

  // lowest free slot
  always_comb begin
    any_free = 1'b0;
    free_s   = '0;
    for (int j = DEPTH - 1; j >= 0; j--) begin
      if (!valid_r[j]) begin
        any_free = 1'b1;
        free_s   = SLOT_W'(j);
      end
    end
  end

  // list position of the slot to delete
  always_comb begin
    hit_pos = '0;
    for (int j = DEPTH - 1; j >= 0; j--) begin
      if ((CNT_W'(j) < cnt_r) && (list_r[j] == req_s)) hit_pos = SLOT_W'(j);
    end
  end

  always_ff @(posedge clk) begin
    dl_rd_r <= dl_mem[rd_addr];
    pr_rd_r <= pr_mem[rd_addr];
    if (dl_we) dl_mem[wr_addr] <= wr_dl;
    if (pr_we) pr_mem[wr_addr] <= cmd_r.period;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    list_r     <= list_nxt;
    due_r      <= due_nxt;
    pos_r      <= pos_nxt;
    n_r        <= n_nxt;
    i_r        <= i_nxt;
    cmd_r      <= cmd_nxt;
    ins_d_r    <= ins_d_nxt;
    ins_s_r    <= ins_s_nxt;
    ins_tick_r <= ins_tick_nxt;
    out_r      <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    valid_nxt     = valid_r;
    list_nxt      = list_r;
    due_nxt       = due_r;
    cnt_nxt       = cnt_r;
    pos_nxt       = pos_r;
    n_nxt         = n_r;
    i_nxt         = i_r;
    cmd_nxt       = cmd_r;
    ins_d_nxt     = ins_d_r;
    ins_s_nxt     = ins_s_r;
    ins_tick_nxt  = ins_tick_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    cmd_pop       = 1'b0;
    rd_addr       = list_r[0];
    dl_we         = 1'b0;
    pr_we         = 1'b0;
    wr_addr       = free_s;
    wr_dl         = cmd_r.time_value;

    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          n_nxt   = '0;
          i_nxt   = '0;
          priority case (kind_t'(cmd.kind))
            KIND_ADD:  state_nxt = S_ADD;
            KIND_DEL:  state_nxt = S_DEL_RD;
            KIND_TICK: state_nxt = S_TK_RD;
            default:   state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          if (!any_free || (cnt_r >= CNT_W'(DEPTH))) begin
            out_nxt   = '{status: ST_FULL, slot_id: '0, due_time: '0, last: 1'b1};
            state_nxt = S_IDLE;
          end else begin
            dl_we             = 1'b1;
            pr_we             = 1'b1;
            valid_nxt[free_s] = 1'b1;
            out_nxt = '{status: ST_ADDED, slot_id: SLOT_BITS'(free_s),
                        due_time: cmd_r.time_value, last: 1'b1};
            ins_d_nxt    = cmd_r.time_value;
            ins_s_nxt    = free_s;
            ins_tick_nxt = 1'b0;
            pos_nxt      = '0;
            state_nxt    = S_INS_RD;
          end
        end
      end
      S_INS_RD: begin
        rd_addr = list_r[pos_r[SLOT_W-1:0]];
        state_nxt = (pos_r < cnt_r) ? S_INS_CMP : S_INS_PUT;
      end
      S_INS_CMP: begin
        if (dl_rd_r <= ins_d_r) begin
          pos_nxt   = pos_r + CNT_W'(1);
          state_nxt = S_INS_RD;
        end else begin
          state_nxt = S_INS_PUT;
        end
      end
      S_INS_PUT: begin
        for (int j = 1; j < DEPTH; j++) begin
          if (CNT_W'(j) > pos_r) list_nxt[j] = list_r[j-1];
        end
        list_nxt[pos_r[SLOT_W-1:0]] = ins_s_r;
        cnt_nxt = cnt_r + CNT_W'(1);
        if (ins_tick_r && !last_fire) begin
          i_nxt     = i_r + DUE_W'(1);
          state_nxt = S_FI_RD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_DEL_RD: begin
        rd_addr   = req_s;
        state_nxt = S_DEL_EMIT;
      end
      S_DEL_EMIT: begin
        // hold the read address so a stalled result keeps its data
        rd_addr = req_s;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (!req_ok || !valid_r[req_s]) begin
            out_nxt = '{status: ST_NOTFOUND, slot_id: cmd_r.slot, due_time: '0,
                        last: 1'b1};
          end else begin
            for (int j = 0; j < DEPTH - 1; j++) begin
              if (SLOT_W'(j) >= hit_pos) list_nxt[j] = list_r[j+1];
            end
            cnt_nxt          = cnt_r - CNT_W'(1);
            valid_nxt[req_s] = 1'b0;
            out_nxt = '{status: ST_DELETED, slot_id: cmd_r.slot, due_time: dl_rd_r,
                        last: 1'b1};
          end
        end
      end
      S_TK_RD: begin
        rd_addr = list_r[0];
        if ((cnt_r != '0) && (n_r < NUM_W'(MAX_RESULTS))) begin
          state_nxt = S_TK_CMP;
        end else begin
          state_nxt = (n_r == '0) ? S_IDLE : S_FI_RD;
        end
      end
      S_TK_CMP: begin
        if (dl_rd_r <= cmd_r.time_value) begin
          due_nxt[n_r[DUE_W-1:0]] = list_r[0];
          for (int j = 0; j < DEPTH - 1; j++) list_nxt[j] = list_r[j+1];
          cnt_nxt   = cnt_r - CNT_W'(1);
          n_nxt     = n_r + NUM_W'(1);
          state_nxt = S_TK_RD;
        end else begin
          state_nxt = (n_r == '0) ? S_IDLE : S_FI_RD;
        end
      end
      S_FI_RD: begin
        rd_addr   = fire_s;
        state_nxt = S_FI_EMIT;
      end
      S_FI_EMIT: begin
        rd_addr = fire_s;
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_nxt = '{status: ST_FIRED, slot_id: SLOT_BITS'(fire_s),
                      due_time: dl_rd_r, last: last_fire};
          if (pr_rd_r != '0) begin
            dl_we        = 1'b1;
            wr_addr      = fire_s;
            wr_dl        = rearm;
            ins_d_nxt    = rearm;
            ins_s_nxt    = fire_s;
            ins_tick_nxt = 1'b1;
            pos_nxt      = '0;
            state_nxt    = S_INS_RD;
          end else begin
            valid_nxt[fire_s] = 1'b0;
            if (last_fire) begin
              state_nxt = S_IDLE;
            end else begin
              i_nxt     = i_r + DUE_W'(1);
              state_nxt = S_FI_RD;
            end
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `PTQ_ASSERT_NOW(a_cnt_bound, clk, rst_n, 1'b1, cnt_r <= CNT_W'(DEPTH))
  `PTQ_ASSERT_NOW(a_cnt_matches_valid, clk, rst_n, state_r == S_IDLE, $countones(valid_r) == 32'(cnt_r))
  `PTQ_ASSERT_NOW(a_fire_count, clk, rst_n, state_r == S_FI_EMIT, (n_r != '0) && (NUM_W'(i_r) < n_r))
endmodule

// File: design/periodic_timer_queue.sv
// add scans the list for its place through the single read port of the deadline store;
// delete reads its slot; tick pops due timers from the list head, then emits a result per
// fired timer and rearms a periodic one, reinserting it by the same list scan
// a two-beat command queue and a result register let both sides stall independently
// reset: synchronous, active low; clears all slots, armed count and handshakes
`timescale 1ns / 1ps
module periodic_timer_queue import ptq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ptq_in_if.sink    in_ch,
  ptq_out_if.source out_ch
);
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd;

  ptq_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop)
  );

  ptq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .out_ch    (out_ch)
  );
endmodule

// File: tb/ptq_checker.sv
// scoreboard for the timer queue: watches command and result beats, keeps its own
// deadline-ordered copy of the timers and compares every result field by field
// depends on ptq_pkg and the channel interfaces in ptq_if
`timescale 1ns / 1ps
module ptq_checker import ptq_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  ptq_in_if    in_mon,
  ptq_out_if   out_mon,
  output int   errors,
  output int   pending,
  output int   checked
);
  localparam logic [TIME_BITS-1:0] TMAX = '1;

  logic [TIME_BITS-1:0] deadline [DEPTH];
  logic [TIME_BITS-1:0] interval [DEPTH];
  bit                   armed    [DEPTH];
  int                   by_due   [$];
  res_t                 expected_q [$];

  function automatic res_t mk(status_t st, int sl, logic [TIME_BITS-1:0] t, bit l);
    res_t r;
    r.status   = st;
    r.slot_id  = sl[SLOT_BITS-1:0];
    r.due_time = t;
    r.last     = l;
    return r;
  endfunction

  // sorted insert behind every timer with an equal deadline
  function automatic void arm(int s);
    int pos;
    pos = 0;
    while (pos < by_due.size() && deadline[by_due[pos]] <= deadline[s]) pos++;
    by_due.insert(pos, s);
  endfunction

  function automatic void predict(logic [KIND_BITS-1:0] k, logic [SLOT_BITS-1:0] sl,
                                  logic [TIME_BITS-1:0] tv, logic [TIME_BITS-1:0] pr);
    int s;
    int n;
    int fired [$];
    case (k)
      KIND_ADD: begin
        s = 0;
        while (s < DEPTH && armed[s]) s++;
        if (s >= DEPTH) begin
          expected_q.push_back(mk(ST_FULL, 0, '0, 1));
        end else begin
          armed[s]    = 1;
          deadline[s] = tv;
          interval[s] = pr;
          arm(s);
          expected_q.push_back(mk(ST_ADDED, s, tv, 1));
        end
      end
      KIND_DEL: begin
        if (!armed[sl]) begin
          expected_q.push_back(mk(ST_NOTFOUND, sl, '0, 1));
        end else begin
          foreach (by_due[i]) if (by_due[i] == sl) begin
            by_due.delete(i);
            break;
          end
          armed[sl] = 0;
          expected_q.push_back(mk(ST_DELETED, sl, deadline[sl], 1));
        end
      end
      KIND_TICK: begin
        n = 0;
        while (n < by_due.size() && n < MAX_RESULTS && deadline[by_due[n]] <= tv) begin
          fired.push_back(by_due[n]);
          n++;
        end
        repeat (n) void'(by_due.pop_front());
        foreach (fired[i]) begin
          s = fired[i];
          expected_q.push_back(mk(ST_FIRED, s, deadline[s], i == n - 1));
          if (interval[s] != 0) begin
            deadline[s] = (interval[s] > TMAX - deadline[s]) ? TMAX
                                                             : deadline[s] + interval[s];
            arm(s);
          end else begin
            armed[s] = 0;
          end
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      foreach (armed[i]) armed[i] = 0;
      by_due.delete();
      expected_q.delete();
      errors  = 0;
      checked = 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        checked++;
        if (expected_q.size() == 0) begin
          errors++;
          $display("%0t: unexpected result beat status=%0d slot=%0d due=%0d last=%0d",
                   $time, out_mon.status, out_mon.slot_id, out_mon.due_time, out_mon.last);
        end else begin
          want = expected_q.pop_front();
          if (out_mon.status !== want.status || out_mon.slot_id !== want.slot_id ||
              out_mon.due_time !== want.due_time || out_mon.last !== want.last) begin
            errors++;
            $display("%0t: mismatch expected status=%0d slot=%0d due=%0d last=%0d",
                     $time, want.status, want.slot_id, want.due_time, want.last);
            $display("%0t:          actual   status=%0d slot=%0d due=%0d last=%0d",
                     $time, out_mon.status, out_mon.slot_id, out_mon.due_time,
                     out_mon.last);
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict(in_mon.kind, in_mon.slot, in_mon.time_value, in_mon.period);
    end
    pending = expected_q.size();
  end
endmodule

// File: tb/tb.sv
// stimulus and verdict for the timer queue: directed corner cases, then random
// add/delete/tick traffic with random stalls on both channels
// depends on ptq_pkg, ptq_if, periodic_timer_queue and ptq_checker
`timescale 1ns / 1ps
module tb;
  import ptq_pkg::*;

  localparam logic [TIME_BITS-1:0] TMAX = '1;

  logic clk;
  logic rst_n;
  int   errors, pending, checked;
  int   n_add, n_del, n_tick, n_other;
  bit   no_idle;
  bit   long_hold_req;
  int   hold_cnt;
  logic [TIME_BITS-1:0] now;

  ptq_in_if  in_ch ();
  ptq_out_if out_ch ();

  periodic_timer_queue u_top (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  ptq_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
    .errors(errors), .pending(pending), .checked(checked)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic logic [TIME_BITS-1:0] rand_time();
    return TIME_BITS'({$urandom, $urandom});
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // receiver: random stalls, occasional long stall, plus a long hold on request
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 0;
      hold_cnt = 0;
    end else if (long_hold_req) begin
      long_hold_req = 0;
      hold_cnt = 400;
      out_ch.ready <= 0;
    end else if (hold_cnt > 0) begin
      hold_cnt--;
      out_ch.ready <= 0;
    end else if (no_idle) begin
      out_ch.ready <= 1;
    end else begin
      if ($urandom_range(0, 99) < 3) hold_cnt = $urandom_range(10, 40);
      out_ch.ready <= ($urandom_range(0, 9) < 7);
    end
  end

  task automatic send(kind_t k, logic [SLOT_BITS-1:0] sl, logic [TIME_BITS-1:0] tv,
                      logic [TIME_BITS-1:0] pr);
    int gap;
    in_ch.kind       <= k;
    in_ch.slot       <= sl;
    in_ch.time_value <= tv;
    in_ch.period     <= pr;
    in_ch.valid      <= 1;
    do @(posedge clk); while (!in_ch.ready);
    case (k)
      KIND_ADD:  n_add++;
      KIND_DEL:  n_del++;
      KIND_TICK: n_tick++;
      default:   n_other++;
    endcase
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop offering beats, then wait until every expected result has come
  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int r;
    logic [TIME_BITS-1:0] pr;
    rst_n = 0;
    in_ch.valid <= 0;
    in_ch.kind <= KIND_ADD;
    in_ch.slot <= '0;
    in_ch.time_value <= '0;
    in_ch.period <= '0;
    long_hold_req = 0;
    no_idle = 0;
    now = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed corners
    send(KIND_TICK, 0, 0, 0);
    send(KIND_DEL, 5, 0, 0);
    send(KIND_NONE, 15, TMAX, TMAX);
    send(KIND_ADD, 0, 10, 0);
    send(KIND_ADD, 0, 10, 5);
    send(KIND_ADD, 0, TMAX, TMAX);
    send(KIND_ADD, 0, TMAX - 3, TMAX);
    send(KIND_TICK, 0, 10, 0);
    send(KIND_DEL, 1, 0, 0);
    send(KIND_TICK, 0, TMAX, 0);
    send(KIND_DEL, 2, 0, 0);
    send(KIND_DEL, 3, 0, 0);
    for (int i = 0; i < DEPTH; i++)
      send(KIND_ADD, 0, TIME_BITS'(i * 7), TIME_BITS'((i % 2) ? 3 : 0));
    send(KIND_ADD, 0, 1, 1);
    send(KIND_TICK, 0, TMAX, 0);
    drain();

    // random traffic
    for (int i = 0; i < 150; i++) begin
      if (i == 50) long_hold_req = 1;
      if (i == 90) drain();
      no_idle = (i >= 100 && i < 120);
      r = $urandom_range(0, 99);
      if (r < 40) begin
        r = $urandom_range(0, 9);
        pr = (r < 3) ? '0 : (r < 9) ? TIME_BITS'($urandom_range(1, 100)) : rand_time();
        send(KIND_ADD, SLOT_BITS'($urandom),
             ($urandom_range(0, 19) == 0) ? rand_time()
                                          : now + TIME_BITS'($urandom_range(0, 200)), pr);
      end else if (r < 62) begin
        send(KIND_DEL, SLOT_BITS'($urandom_range(0, 15)), rand_time(), rand_time());
      end else if (r < 95) begin
        now = now + TIME_BITS'($urandom_range(0, 80));
        send(KIND_TICK, SLOT_BITS'($urandom), ($urandom_range(0, 29) == 0) ? TMAX : now,
             rand_time());
      end else begin
        send(kind_t'($urandom_range(0, 3)), SLOT_BITS'($urandom), rand_time(), rand_time());
      end
    end

    drain();
    repeat (1000) @(posedge clk);
    $display("covered %0d adds, %0d deletes, %0d ticks, %0d ignored or noise commands",
             n_add, n_del, n_tick, n_other);
    $display("%0d result beats compared, %0d mismatches", checked, errors);
    if (errors == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end
endmodule
